FILE: rtl/core/mrr_pkg.sv
// Shared constants for the Miller-Rabin round block.
// Used by the channel interfaces and by the top level; depends on nothing.
package mrr_pkg;

    // Width of the candidate and base fields on the input channel.
    localparam int unsigned FIELD_WIDTH = 62;

    // Width of the verdict field on the output channel.
    localparam int unsigned VERDICT_WIDTH = 1;

    // The only even number that counts as prime.
    localparam int unsigned SMALLEST_PRIME = 2;

    // Verdict codes.
    localparam logic [VERDICT_WIDTH-1:0] VERDICT_COMPOSITE = 1'b0;
    localparam logic [VERDICT_WIDTH-1:0] VERDICT_PRIME     = 1'b1;

endpackage

FILE: rtl/core/mrr_channels.sv
// Valid/ready channel interfaces for the Miller-Rabin round block.
// Depends on mrr_pkg for the field widths.

// Input channel: one candidate number and one witness base per transfer.
interface mrr_item_if;
    logic                              valid;
    logic                              ready;
    logic [mrr_pkg::FIELD_WIDTH-1:0]   candidate;
    logic [mrr_pkg::FIELD_WIDTH-1:0]   base;

    modport source (output valid, output candidate, output base, input ready);
    modport sink   (input valid, input candidate, input base, output ready);
endinterface

// Output channel: one verdict per transfer.
interface mrr_result_if;
    logic                              valid;
    logic                              ready;
    logic [mrr_pkg::VERDICT_WIDTH-1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

FILE: rtl/core/miller_rabin_round_top.sv
// Top level of the Miller-Rabin round: sequencer around one shared modular multiplier.
// Depends on mrr_pkg, the channel interfaces in mrr_channels and mrr_mulmod.
//
//  Channel    Dir  Fields              Meaning
//  i_item     in   candidate, base     number to test and its witness base
//  o_result   out  verdict             1 probably prime, 0 composite
//
// One item at a time. Even, zero, one and two go straight to the verdict. An odd
// candidate runs the base reduction, a trailing-zero scan of n-1, square-and-multiply
// over the odd part and the final squarings, every multiplication on the one
// bit-serial multiplier, which works through the bits of its multiplier operand.
// Reset is synchronous and active low; it clears the sequencer and the output valid,
// and i_item.ready stays low while reset is held.
// i_item.ready is high only while the sequencer is idle; a waiting result holds in
// the output register, the next item still runs, and its verdict waits for the
// register before the input opens again.
module miller_rabin_round_top #(
    parameter int unsigned NUMBER_WIDTH = 62
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mrr_item_if.sink       i_item,
    mrr_result_if.source   o_result
);

    localparam int unsigned CNT_W = $clog2(NUMBER_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_FIND,
        S_POW_CHK,
        S_POW_MUL,
        S_POW_SQR,
        S_SQUARE,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [NUMBER_WIDTH-1:0]         r_modulus;
    logic [NUMBER_WIDTH-1:0]         r_exp;
    logic [CNT_W-1:0]                r_twos;
    logic [NUMBER_WIDTH-1:0]         r_acc;
    logic [NUMBER_WIDTH-1:0]         r_x;
    logic [mrr_pkg::VERDICT_WIDTH-1:0] r_verdict;
    logic                            r_mul_start;
    logic [NUMBER_WIDTH-1:0]         r_mul_x;
    logic [NUMBER_WIDTH-1:0]         r_mul_y;
    logic                            r_out_valid;
    logic [mrr_pkg::VERDICT_WIDTH-1:0] r_out_verdict;

    logic                            mul_done;
    logic [NUMBER_WIDTH-1:0]         mul_product;
    logic [NUMBER_WIDTH-1:0]         in_n;
    logic [NUMBER_WIDTH-1:0]         in_a;
    logic [NUMBER_WIDTH-1:0]         modulus_m1;
    logic                            in_xfer;
    logic                            out_free;

    localparam logic [NUMBER_WIDTH-1:0] ONE = NUMBER_WIDTH'(1);
    localparam logic [NUMBER_WIDTH-1:0] TWO = NUMBER_WIDTH'(mrr_pkg::SMALLEST_PRIME);

    // Shared modular multiplier.
    mrr_mulmod #(
        .WIDTH (NUMBER_WIDTH)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_x       (r_mul_x),
        .i_y       (r_mul_y),
        .i_modulus (r_modulus),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    // Handshake and operand views.
    assign in_n       = i_item.candidate[NUMBER_WIDTH-1:0];
    assign in_a       = i_item.base[NUMBER_WIDTH-1:0];
    assign modulus_m1 = r_modulus - ONE;
    assign in_xfer    = i_item.valid && i_item.ready;
    assign out_free   = !r_out_valid || o_result.ready;

    assign i_item.ready     = i_rst_n && (r_state == S_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.verdict = r_out_verdict;

    // Sequencer, multiplier requests and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            // A new verdict loaded in S_DONE takes the place of the one leaving.
            if (r_out_valid && o_result.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_modulus <= in_n;
                        if (in_n == TWO) begin
                            r_verdict <= mrr_pkg::VERDICT_PRIME;
                            r_state   <= S_DONE;
                        end else if (in_n < TWO || !in_n[0]) begin
                            r_verdict <= mrr_pkg::VERDICT_COMPOSITE;
                            r_state   <= S_DONE;
                        end else begin
                            // The base mod n is 1 times the base, summed bit by bit.
                            r_mul_x     <= ONE;
                            r_mul_y     <= in_a;
                            r_mul_start <= 1'b1;
                            r_state     <= S_REDUCE;
                        end
                    end
                end

                S_REDUCE: begin
                    if (mul_done) begin
                        r_x     <= mul_product;
                        r_exp   <= modulus_m1;
                        r_twos  <= '0;
                        r_state <= S_FIND;
                    end
                end

                // Strip the factors of two from n-1, one per cycle.
                S_FIND: begin
                    if (!r_exp[0]) begin
                        r_exp  <= r_exp >> 1;
                        r_twos <= r_twos + CNT_W'(1);
                    end else begin
                        r_acc   <= ONE;
                        r_state <= S_POW_CHK;
                    end
                end

                // Square-and-multiply over the odd part, low bit first.
                S_POW_CHK: begin
                    r_mul_start <= 1'b1;
                    if (r_exp == '0) begin
                        r_x     <= r_acc;
                        r_mul_x <= r_acc;
                        r_mul_y <= r_acc;
                        r_state <= S_SQUARE;
                    end else if (r_exp[0]) begin
                        r_mul_x <= r_acc;
                        r_mul_y <= r_x;
                        r_state <= S_POW_MUL;
                    end else begin
                        r_mul_x <= r_x;
                        r_mul_y <= r_x;
                        r_state <= S_POW_SQR;
                    end
                end

                S_POW_MUL: begin
                    if (mul_done) begin
                        r_acc       <= mul_product;
                        r_mul_x     <= r_x;
                        r_mul_y     <= r_x;
                        r_mul_start <= 1'b1;
                        r_state     <= S_POW_SQR;
                    end
                end

                S_POW_SQR: begin
                    if (mul_done) begin
                        r_x     <= mul_product;
                        r_exp   <= r_exp >> 1;
                        r_state <= S_POW_CHK;
                    end
                end

                // Repeated squaring: look for a non-trivial root of one.
                S_SQUARE: begin
                    if (mul_done) begin
                        if (mul_product == ONE && r_x != ONE && r_x != modulus_m1) begin
                            r_verdict <= mrr_pkg::VERDICT_COMPOSITE;
                            r_state   <= S_DONE;
                        end else if (r_twos == CNT_W'(1)) begin
                            r_verdict <= (mul_product == ONE) ? mrr_pkg::VERDICT_PRIME
                                                              : mrr_pkg::VERDICT_COMPOSITE;
                            r_state   <= S_DONE;
                        end else begin
                            r_x         <= mul_product;
                            r_twos      <= r_twos - CNT_W'(1);
                            r_mul_x     <= mul_product;
                            r_mul_y     <= mul_product;
                            r_mul_start <= 1'b1;
                        end
                    end
                end

                // Hand the verdict to the output register once it is free.
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_verdict <= r_verdict;
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/mrr_mulmod.sv
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
// Stand-alone; the caller holds the modulus stable while the unit is busy.
module mrr_mulmod #(
    parameter int unsigned WIDTH = 62
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_done,
    output logic [WIDTH-1:0] o_product
);

    logic             r_busy;
    logic             r_done;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;

    logic [WIDTH:0]   sum_ext;
    logic [WIDTH:0]   dbl_ext;
    logic [WIDTH:0]   mod_ext;
    logic [WIDTH-1:0] n_acc;
    logic [WIDTH-1:0] n_x;

    // One step: conditionally add x into the accumulator and double x, both mod n.
    // Operands stay below the modulus, so each sum is below twice the modulus.
    always_comb begin
        mod_ext = {1'b0, i_modulus};
        sum_ext = {1'b0, r_acc} + {1'b0, r_x};
        dbl_ext = {r_x, 1'b0};
        if (r_y[0]) begin
            n_acc = (sum_ext >= mod_ext) ? WIDTH'(sum_ext - mod_ext) : sum_ext[WIDTH-1:0];
        end else begin
            n_acc = r_acc;
        end
        n_x = (dbl_ext >= mod_ext) ? WIDTH'(dbl_ext - mod_ext) : dbl_ext[WIDTH-1:0];
    end

    // Sequencing: load on start, step until the multiplier runs out of set bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_acc  <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
            end else if (r_busy) begin
                if (r_y == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= n_acc;
                    r_x   <= n_x;
                    r_y   <= r_y >> 1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule
